// ===== design/isbe_pkg.sv =====
// Shared types and constants for the index shuffle batch engine.
// No dependencies; imported by the core, cfg, ctrl and checker files.
package isbe_pkg;

    // Sizing defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int MAX_BATCH_DEF   = 64;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int BSIZE_W  = 7;
    localparam int SIZE_W   = 11;
    localparam int CAP_W    = 7;

    // Generation tag stored next to each table entry
    localparam int EPOCH_W = 8;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [SIZE_W-1:0] PERM_SIZE_RST = 11'd1024;
    localparam logic [CAP_W-1:0]  BATCH_CAP_RST = 7'd64;

    // Register index decoded from paddr[2]
    localparam logic REG_PERM_SIZE = 1'b0;
    localparam logic REG_BATCH_CAP = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_SHUFFLE = 2'd1,
        OP_BATCH   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INDEX     = 2'd0,
        ST_DONE      = 2'd1,
        ST_BAD_BATCH = 2'd2,
        ST_BAD_PICK  = 2'd3
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0] perm_size;
        logic [CAP_W-1:0]  batch_capacity;
    } cfg_t;

endpackage

// ===== design/index_shuffle_batch_engine_core.sv =====
// Flow: a restart result goes through S_RESP into the result queue; a shuffle step
// result follows the swap's two reads and two writes on the table RAM ports.
// Batch of n: indexes come from the pipelined RAM read, one index per cycle while
// the result queue has room; the next item is accepted once the batch is drained.
// Reset: synchronous, active low; a clearing pass over the whole table follows reset
// and every 255th restart (tag wrap), during which no item is accepted.
module index_shuffle_batch_engine_core
    import isbe_pkg::*;
#(
    parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int  MAX_BATCH   = MAX_BATCH_DEF,
    localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // Input items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [IDX_W-1:0]    s_pick,
    input  logic [BSIZE_W-1:0]  s_batch_size,
    // Result items
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [IDX_W-1:0]    m_index_value,
    output logic                m_last
);

    localparam int MW = EPOCH_W + IDX_W;
    localparam int QW = STATUS_W + IDX_W + 1;

    cfg_t             cfg;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [MW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [MW-1:0]    ram_rdata;
    logic [1:0]       q_space;
    logic             q_push;
    logic [QW-1:0]    q_data;
    logic [QW-1:0]    m_data;

    isbe_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isbe_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_BATCH   (MAX_BATCH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_pick       (s_pick),
        .s_batch_size (s_batch_size),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .q_space      (q_space),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    // Permutation table: value plus generation tag per entry
    isbe_ram #(
        .W     (MW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isbe_outq #(
        .W (QW)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .space     (q_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Split the queued item into its fields
    assign m_status      = m_data[QW-1 -: STATUS_W];
    assign m_index_value = m_data[IDX_W:1];
    assign m_last        = m_data[0];

endmodule

// ===== design/isbe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module isbe_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/isbe_outq.sv =====
// Two-entry result queue between the sequencer and the result channel.
// Reports free slots, counting a pop in the same cycle, for read credit.
module isbe_outq #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic [1:0]   space,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [W-1:0] m_data
);

    logic [W-1:0] slot_reg [2];
    logic [1:0]   count_reg;
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic         pop;

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid & m_ready;
    assign space   = 2'd2 - count_reg + {1'b0, pop};

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/isbe_cfg.sv =====
// APB-style configuration registers: perm_size and batch_capacity.
// Depends on isbe_pkg for widths, reset values and register indexes.
module isbe_cfg
    import isbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [SIZE_W-1:0] perm_size_reg;
    logic [CAP_W-1:0]  batch_cap_reg;
    logic              reg_sel;
    logic              wr_en;

    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_size_reg <= PERM_SIZE_RST;
            batch_cap_reg <= BATCH_CAP_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_PERM_SIZE: perm_size_reg <= pwdata[SIZE_W-1:0];
                REG_BATCH_CAP: batch_cap_reg <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_sel)
            REG_PERM_SIZE: prdata = APB_DW'(perm_size_reg);
            REG_BATCH_CAP: prdata = APB_DW'(batch_cap_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.perm_size      = perm_size_reg;
    assign cfg.batch_capacity = batch_cap_reg;

endmodule

// ===== design/isbe_ctrl.sv =====
// Sequencer: checks items, runs swaps and batch reads against the table RAM.
// Depends on isbe_pkg; drives the table RAM and the result queue.
module isbe_ctrl
    import isbe_pkg::*;
#(
    parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int  MAX_BATCH   = MAX_BATCH_DEF,
    localparam int IDX_W  = $clog2(MAX_ENTRIES),
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
    localparam int SZ_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W,
    localparam int CMP_W  = SZ_W + BSIZE_W,
    localparam int BCNT_W = $clog2(MAX_BATCH + 1),
    localparam int MW     = EPOCH_W + IDX_W,
    localparam int QW     = STATUS_W + IDX_W + 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_op,
    input  logic [IDX_W-1:0]   s_pick,
    input  logic [BSIZE_W-1:0] s_batch_size,
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output logic [MW-1:0]      ram_wdata,
    output logic [IDX_W-1:0]   ram_raddr,
    input  logic [MW-1:0]      ram_rdata,
    input  logic [1:0]         q_space,
    output logic               q_push,
    output logic [QW-1:0]      q_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWAP_RD,
        S_SWAP_WAIT,
        S_SWAP_WR,
        S_BATCH,
        S_RESP
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   rp_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   pick_reg;
    logic [IDX_W-1:0]   a_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   bptr_reg;
    logic [BCNT_W-1:0]  bcnt_reg;
    logic               pend_reg;
    logic               pend_last_reg;
    status_t            resp_status_reg;
    logic               clear_after_reg;

    logic [SZ_W-1:0]    size_ext;
    logic [SZ_W-1:0]    eff_size;
    logic [CAP_W-1:0]   eff_cap;
    logic               pick_bad;
    logic               batch_bad;
    logic [IDX_W-1:0]   rd_val;
    logic               issue;
    logic               accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid & s_ready;

    // Clamp the configured sizes
    assign size_ext = SZ_W'(cfg.perm_size);
    assign eff_size = (size_ext > SZ_W'(MAX_ENTRIES)) ? SZ_W'(MAX_ENTRIES) : size_ext;
    assign eff_cap  = (cfg.batch_capacity > CAP_W'(MAX_BATCH)) ? CAP_W'(MAX_BATCH)
                                                             : cfg.batch_capacity;

    // Range checks for shuffle and batch items
    assign pick_bad  = (SZ_W'(step_reg) >= eff_size) ||
                       (SZ_W'(s_pick) < SZ_W'(step_reg)) ||
                       (SZ_W'(s_pick) >= eff_size);
    assign batch_bad = (CAP_W'(s_batch_size) > eff_cap) ||
                       ((CMP_W'(rp_reg) + CMP_W'(s_batch_size)) > CMP_W'(eff_size));

    // An entry whose tag is stale reads as its own index
    assign rd_val = (ram_rdata[MW-1:IDX_W] == epoch_reg) ? ram_rdata[IDX_W-1:0]
                                                         : rd_addr_reg;

    // Issue a batch read only when a queue slot is sure to be free
    assign issue = (state_reg == S_BATCH) && (bcnt_reg != '0) &&
                   (q_space > {1'b0, pend_reg});

    // Read address select
    always_comb begin
        unique case (state_reg)
            S_IDLE:    ram_raddr = s_pick;
            S_SWAP_RD: ram_raddr = step_reg[IDX_W-1:0];
            default:   ram_raddr = bptr_reg;
        endcase
    end

    // Write port: clearing pass and the two halves of a swap
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_SWAP_WAIT: begin
                ram_we    = 1'b1;
                ram_waddr = pick_reg;
                ram_wdata = {epoch_reg, rd_val};
            end
            S_SWAP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = step_reg[IDX_W-1:0];
                ram_wdata = {epoch_reg, a_reg};
            end
            default: ;
        endcase
    end

    // Result push: batch index items or a single status item
    assign q_push = pend_reg || ((state_reg == S_RESP) && (q_space != 2'd0));
    assign q_data = pend_reg ? {ST_INDEX, rd_val, pend_last_reg}
                             : {resp_status_reg, IDX_W'(0), 1'b1};

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_addr_reg   <= ram_raddr;
        pend_last_reg <= (bcnt_reg == BCNT_W'(1));
        if (state_reg == S_SWAP_RD) begin
            a_reg <= rd_val;
        end
        if (accept) begin
            pick_reg <= s_pick;
        end
    end

    // State machine and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            step_reg        <= '0;
            rp_reg          <= '0;
            epoch_reg       <= EPOCH_W'(1);
            clr_reg         <= '0;
            bptr_reg        <= '0;
            bcnt_reg        <= '0;
            pend_reg        <= 1'b0;
            resp_status_reg <= ST_DONE;
            clear_after_reg <= 1'b0;
        end else begin
            pend_reg <= issue;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(MAX_ENTRIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        case (op_t'(s_op))
                            OP_RESTART: begin
                                step_reg        <= '0;
                                rp_reg          <= '0;
                                resp_status_reg <= ST_DONE;
                                state_reg       <= S_RESP;
                                // Bump the tag; on wrap, scrub the table before the next item
                                if (epoch_reg == '1) begin
                                    epoch_reg       <= EPOCH_W'(1);
                                    clear_after_reg <= 1'b1;
                                end else begin
                                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                                end
                            end
                            OP_SHUFFLE: begin
                                if (pick_bad) begin
                                    resp_status_reg <= ST_BAD_PICK;
                                    state_reg       <= S_RESP;
                                end else begin
                                    state_reg <= S_SWAP_RD;
                                end
                            end
                            OP_BATCH: begin
                                if (batch_bad) begin
                                    resp_status_reg <= ST_BAD_BATCH;
                                    state_reg       <= S_RESP;
                                end else if (s_batch_size == '0) begin
                                    resp_status_reg <= ST_DONE;
                                    state_reg       <= S_RESP;
                                end else begin
                                    bcnt_reg  <= BCNT_W'(s_batch_size);
                                    bptr_reg  <= rp_reg[IDX_W-1:0];
                                    rp_reg    <= rp_reg + CNT_W'(s_batch_size);
                                    state_reg <= S_BATCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SWAP_RD: begin
                    state_reg <= S_SWAP_WAIT;
                end
                S_SWAP_WAIT: begin
                    state_reg <= S_SWAP_WR;
                end
                S_SWAP_WR: begin
                    step_reg        <= step_reg + CNT_W'(1);
                    resp_status_reg <= ST_DONE;
                    state_reg       <= S_RESP;
                end
                S_BATCH: begin
                    if (issue) begin
                        bcnt_reg <= bcnt_reg - BCNT_W'(1);
                        bptr_reg <= bptr_reg + IDX_W'(1);
                    end
                    if ((bcnt_reg == '0) && !pend_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (q_space != 2'd0) begin
                        clr_reg         <= '0;
                        clear_after_reg <= 1'b0;
                        state_reg       <= clear_after_reg ? S_CLEAR : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/isbe_checker.sv =====
// Port-level checker for the index shuffle batch engine, bound to the top level.
// Depends on isbe_pkg for op and status codes.
module isbe_checker
    import isbe_pkg::*;
#(
    parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [OP_W-1:0]     s_op,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [IDX_W-1:0]    m_index_value,
    input logic                m_last
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_index_value) && $stable(m_last))
        else $error("result item changed while stalled");

    // Status items carry a zero index and close their item
    a_status_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_INDEX) |-> m_last && (m_index_value == '0))
        else $error("status item with index or without last");

    // An item that does work closes the input in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        ((s_op == OP_RESTART) || (s_op == OP_SHUFFLE) || (s_op == OP_BATCH))
        |=> !s_ready)
        else $error("input ready right after accepting an item");

    // The clearing pass after reset keeps the input closed
    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("input ready during the clearing pass");

endmodule

bind index_shuffle_batch_engine_core isbe_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_isbe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_op          (s_op),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_index_value (m_index_value),
    .m_last        (m_last)
);
